// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and helpers for the base64 stream encoder.
package b64e_pkg;

   // Register reset value and default group queue depth
   localparam logic [5:0] GPL_RESET = 6'd19;
   localparam int unsigned GROUP_QUEUE_DEPTH = 2;

   // ASCII codes for padding, line breaks and the alphabet ranges
   localparam logic [7:0] CHAR_PAD = 8'h3d;   // '='
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_UA  = 8'h41;   // 'A'
   localparam logic [7:0] CHAR_LA  = 8'h61;   // 'a'
   localparam logic [7:0] CHAR_D0  = 8'h30;   // '0'
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;

   // Sextet ranges of the alphabet
   localparam logic [5:0] SEXT_LOWER = 6'd26;
   localparam logic [5:0] SEXT_DIGIT = 6'd52;
   localparam logic [5:0] SEXT_PLUS  = 6'd62;

   // Number of bytes held by the front end
   typedef enum logic [1:0] {
      PH_EMPTY,
      PH_ONE,
      PH_TWO
   } phase_type;

   // One group handed from front end to back end
   typedef struct packed {
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [1:0] nbytes;   // 1 to 3 real bytes
      logic       eom;
   } group_type;

   // Map a 6-bit value to its alphabet character
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < SEXT_LOWER) begin
         ch = CHAR_UA + {2'b00, v};
      end else if (v < SEXT_DIGIT) begin
         ch = CHAR_LA + {2'b00, v - SEXT_LOWER};
      end else if (v < SEXT_PLUS) begin
         ch = CHAR_D0 + {2'b00, v - SEXT_DIGIT};
      end else if (v == SEXT_PLUS) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: collects raw bytes into groups of up to three.
module b64e_front
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   output logic       push_valid,
   input  logic       push_ready,
   output group_type  push_group
);

   phase_type   phase_ff, phase_in;
   logic [15:0] pend_ff, pend_in;
   logic        accept;
   logic        completes;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & req_tready;

   // A group closes on the third byte or on the final byte
   assign completes  = (phase_ff == PH_TWO) | req_tlast;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      if (accept) begin
         if (completes) begin
            phase_in = PH_EMPTY;
            pend_in  = 16'h0000;
         end else begin
            unique case (phase_ff)
               PH_EMPTY: begin
                  phase_in = PH_ONE;
                  pend_in  = {req_tdata, 8'h00};
               end
               PH_ONE: begin
                  phase_in = PH_TWO;
                  pend_in  = {pend_ff[15:8], req_tdata};
               end
               default: begin
                  phase_in = PH_EMPTY;
                  pend_in  = 16'h0000;
               end
            endcase
         end
      end
   end

   // Outputs: group handed to the queue
   always_comb begin
      push_valid      = accept & completes;
      push_group.eom  = req_tlast;
      unique case (phase_ff)
         PH_ONE: begin
            push_group.b1     = pend_ff[15:8];
            push_group.b2     = req_tdata;
            push_group.b3     = 8'h00;
            push_group.nbytes = 2'd2;
         end
         PH_TWO: begin
            push_group.b1     = pend_ff[15:8];
            push_group.b2     = pend_ff[7:0];
            push_group.b3     = req_tdata;
            push_group.nbytes = 2'd3;
         end
         default: begin
            push_group.b1     = req_tdata;
            push_group.b2     = 8'h00;
            push_group.b3     = 8'h00;
            push_group.nbytes = 2'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_EMPTY;
         pend_ff  <= 16'h0000;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ===== rtl/b64e_fifo.sv =====
// Short group queue between front end and back end.
module b64e_fifo
   import b64e_pkg::*;
#(
   parameter int unsigned DEPTH = GROUP_QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  group_type push_group,
   output logic      pop_valid,
   input  logic      pop_ready,
   output group_type pop_group
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   group_type     slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_group  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: turns queued groups into characters, line breaks and flags.
module b64e_back
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [5:0] groups_per_line,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  group_type  pop_group,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   localparam logic [2:0] IDX_GROUP_END = 3'd3;
   localparam logic [2:0] IDX_CR        = 3'd4;
   localparam logic [2:0] IDX_LF        = 3'd5;

   logic [2:0] idx_ff, idx_in;
   logic [5:0] gol_ff, gol_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic [6:0] gol_next;
   logic       brk;
   logic       load;
   logic       final_char;
   logic [7:0] ch;

   // Line break after this group
   assign gol_next   = {1'b0, gol_ff} + 7'd1;
   assign brk        = (groups_per_line != 6'd0) && (gol_next >= {1'b0, groups_per_line});
   assign final_char = (idx_ff == (brk ? IDX_LF : IDX_GROUP_END));
   assign load       = pop_valid & (~out_valid_ff | rsp_tready);
   assign pop_ready  = load & final_char;

   // Character for the current slot of the group
   always_comb begin
      case (idx_ff)
         3'd0: ch = sextet_char(pop_group.b1[7:2]);
         3'd1: ch = sextet_char({pop_group.b1[1:0], pop_group.b2[7:4]});
         3'd2: ch = (pop_group.nbytes >= 2'd2)
                    ? sextet_char({pop_group.b2[3:0], pop_group.b3[7:6]}) : CHAR_PAD;
         3'd3: ch = (pop_group.nbytes == 2'd3)
                    ? sextet_char(pop_group.b3[5:0]) : CHAR_PAD;
         IDX_CR: ch = CHAR_CR;
         default: ch = CHAR_LF;
      endcase
   end

   // Slot counter, line count and output register
   always_comb begin
      idx_in       = idx_ff;
      gol_in       = gol_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      char_in      = char_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (load) begin
         out_valid_in = 1'b1;
         char_in      = ch;
         last_in      = final_char;
         done_in      = final_char & pop_group.eom;
         if (final_char) begin
            idx_in = 3'd0;
            if (pop_group.eom || brk || groups_per_line == 6'd0) begin
               gol_in = 6'd0;
            end else begin
               gol_in = gol_next[5:0];
            end
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         gol_ff       <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         gol_ff       <= gol_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Base64 stream encoder (standard alphabet, '=' padding, CR LF line breaks).
// Raw bytes enter one per transfer on req_; the last byte of a message has
// req_tlast set. Every three bytes, or the final short group, give four
// characters on rsp_, followed by CR LF once groups_per_line groups have
// been written on the line (csr_wr_data = 0 turns breaks off; reset value 19).
// rsp_tlast marks the last character caused by an input byte, rsp_tuser the
// final character of the message. The output runs at one character per
// cycle while rsp_tready is high, set by the single output register; a
// group gives four characters, or six if it closes a line. Input bytes are
// taken one per cycle while the two-entry group queue has room; a closing
// byte's group passes the queue and the output register before its first
// character appears. Write the register only while the encoder is idle.
module base64_stream_encoder
   import b64e_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = GROUP_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast,
   output logic       rsp_tuser,    // [0] message_done
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   logic [5:0] gpl_ff, gpl_in;
   logic       push_valid;
   logic       push_ready;
   group_type  push_group;
   logic       pop_valid;
   logic       pop_ready;
   group_type  pop_group;

   // Line length register
   assign gpl_in = csr_wr_en ? csr_wr_data : gpl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gpl_ff <= GPL_RESET;
      end else begin
         gpl_ff <= gpl_in;
      end
   end

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group)
   );

   b64e_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .groups_per_line (gpl_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_group       (pop_group),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser)
   );

`ifndef SYNTHESIS
   // End of message is always the last character of its byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("message_done without last_of_run");

   // LF only ever closes the characters of a byte
   a_lf_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CHAR_LF |-> rsp_tlast)
      else $error("LF not marked last");

   // A group leaves the queue only while the output register can take it
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> pop_valid && (!rsp_tvalid || rsp_tready))
      else $error("group popped without output room");

   // Output is empty on the first edge after reset is released
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the base64 stream encoder: directed and random messages.
module testbench;
   import b64e_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 7;
   localparam int PHASE_ITEMS  = 12;
   localparam string ALPHABET  =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // One raw message byte waiting for the driver
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } raw_byte_type;

   // One encoded character as it should appear on rsp_
   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       msg_end;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] data_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [7:0] out_char
   logic       rsp_tlast;
   logic       rsp_tuser;        // [0] message_done
   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;

   raw_byte_type  pending_bytes_q[$];
   enc_char_type  expected_chars[$];
   int         queued_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   bit         quiet = 1'b0;
   bit         hold_pending = 1'b0;
   bit         hold_done = 1'b0;
   int         hold_left = 0;

   // Encoder state mirror
   phase_type  held_count = PH_EMPTY;
   logic [7:0] held_first = '0;
   logic [7:0] held_second = '0;
   logic [5:0] line_groups = '0;
   logic [5:0] line_limit = GPL_RESET;

   base64_stream_encoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 50) begin
         $display("%0t: mismatch: %s", $time, what);
      end
   endtask

   function automatic enc_char_type plain_char(input logic [7:0] ch);
      enc_char_type c;
      c.ch = ch;
      c.run_end = 1'b0;
      c.msg_end = 1'b0;
      return c;
   endfunction

   // Encode one accepted byte: hold it, or close a group and queue its characters
   function automatic void encode_byte(input logic [7:0] b, input logic eom);
      logic [7:0] b1, b2, b3;
      int         nbytes;
      logic [6:0] cnt;
      enc_char_type  run[$];
      b2 = '0;
      b3 = '0;
      case (held_count)
         PH_EMPTY: begin
            if (!eom) begin
               held_first = b;
               held_count = PH_ONE;
               return;
            end
            b1 = b;
            nbytes = 1;
         end
         PH_ONE: begin
            if (!eom) begin
               held_second = b;
               held_count = PH_TWO;
               return;
            end
            b1 = held_first;
            b2 = b;
            nbytes = 2;
         end
         default: begin
            b1 = held_first;
            b2 = held_second;
            b3 = b;
            nbytes = 3;
         end
      endcase

      run.push_back(plain_char(ALPHABET[b1[7:2]]));
      run.push_back(plain_char(ALPHABET[{b1[1:0], b2[7:4]}]));
      run.push_back(plain_char(nbytes >= 2 ? ALPHABET[{b2[3:0], b3[7:6]}] : CHAR_PAD));
      run.push_back(plain_char(nbytes == 3 ? ALPHABET[b3[5:0]] : CHAR_PAD));

      // line break once the line is full, immediately if the limit was lowered
      if (line_limit != 0) begin
         cnt = {1'b0, line_groups} + 7'd1;
         if (cnt >= {1'b0, line_limit}) begin
            run.push_back(plain_char(CHAR_CR));
            run.push_back(plain_char(CHAR_LF));
            cnt = '0;
         end
         line_groups = cnt[5:0];
      end else begin
         line_groups = '0;
      end

      held_count = PH_EMPTY;
      run[run.size()-1].run_end = 1'b1;
      if (eom) begin
         run[run.size()-1].msg_end = 1'b1;
         line_groups = '0;
      end
      foreach (run[i]) expected_chars.push_back(run[i]);
   endfunction

   // Driver: offers queued bytes, predicts each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes_q.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes_q[0].data;
               req_tlast  <= pending_bytes_q[0].last;
               void'(pending_bytes_q.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_pending && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: compare each output transfer against the oldest expectation
   always @(posedge clock) begin
      enc_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h", rsp_tdata));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.ch)
               report_mismatch($sformatf("char 0x%02h, want 0x%02h", rsp_tdata, want.ch));
            if (rsp_tlast !== want.run_end)
               report_mismatch($sformatf("tlast %b, want %b on 0x%02h",
                                         rsp_tlast, want.run_end, want.ch));
            if (rsp_tuser !== want.msg_end)
               report_mismatch($sformatf("tuser %b, want %b on 0x%02h",
                                         rsp_tuser, want.msg_end, want.ch));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic eom);
      raw_byte_type item;
      item.data = b;
      item.last = eom;
      pending_bytes_q.push_back(item);
      queued_count++;
   endtask

   // Random message body; an open message continues in the next phase
   task automatic queue_message(input int len, input bit close);
      for (int i = 0; i < len; i++) begin
         queue_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
      end
   endtask

   // Wait until every byte is taken and every character has arrived
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes_q.size() != 0 || req_tvalid || expected_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_line_limit(input logic [5:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      line_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int start_count;
      int len;
      logic [5:0] plan[6];

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset line length: one, two and three byte finals, all-zero, all-one, '+'
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'hff, 1'b1);
      queue_byte(8'hfb, 1'b0);
      queue_byte(8'hef, 1'b0);
      queue_byte(8'hbe, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7f, 1'b1);
      wait_idle();

      // One group per line: break after the final group, done on the LF
      write_line_limit(6'd1);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h56, 1'b1);
      queue_byte(8'ha5, 1'b1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h02, 1'b0);
      queue_byte(8'h03, 1'b0);
      queue_byte(8'h04, 1'b0);
      queue_byte(8'h05, 1'b1);
      wait_idle();

      // Longest line, leave the message open with three groups on the line
      write_line_limit(6'd63);
      queue_message(9, 1'b0);
      wait_idle();

      // Limit lowered below the current count: break on the next group
      write_line_limit(6'd2);
      queue_message(4, 1'b1);
      wait_idle();

      // Random phases over several line lengths
      plan[0] = 6'd0;
      plan[1] = 6'd63;
      plan[2] = 6'd1;
      plan[3] = 6'd3;
      plan[4] = 6'($urandom_range(2, 6));
      plan[5] = 6'($urandom_range(0, 63));
      for (int p = 0; p < 6; p++) begin
         write_line_limit(plan[p]);
         quiet = (p == 1);
         start_count = queued_count;
         while (queued_count - start_count < PHASE_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 48)
                                              : $urandom_range(1, 9);
            queue_message(len, !(queued_count - start_count + len >= PHASE_ITEMS &&
                                 $urandom_range(0, 2) == 0));
         end
         if (p == 2) hold_pending = 1'b1;
         wait_idle();
      end

      // Close any message left open
      queue_message(1, 1'b1);
      wait_idle();

      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
